// ===== design/ewh_pkg.sv =====
`timescale 1ns / 1ps
package ewh_pkg;
    localparam int WORD_W = 32;
    localparam int IDX_W = 6;
    localparam int CNT_W = 11;
    localparam int DIFF_W = 33;

    typedef struct packed {
        logic signed [WORD_W-1:0] sample_value;
        logic last_sample;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] bin_index;
        logic signed [WORD_W-1:0] bin_low_edge;
        logic [CNT_W-1:0] bin_count;
        logic [CNT_W-1:0] peak_count;
        logic last_bin;
    } out_item_t;
endpackage

// ===== design/ewh_stream_if.sv =====
`timescale 1ns / 1ps
interface ewh_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/equal_width_histogram.sv =====
`timescale 1ns / 1ps
// Load phase: one sample per cycle, in_ch.ready high while collecting; the last one starts binning.
// Binning: clear each bin count, then per stored sample a read, divider setup,
// NUM_W quotient bits and a count update (NUM_W = 38 at BINS = 16), an end-of-scan step,
// a peak scan over the bins, then per bin result divider setup, NUM_W quotient bits and output.
// Input is stalled from the last sample until the final result is taken.
// Reset (rst_n, async, low) clears control, count, min/max and bin counts.
module equal_width_histogram #(
    parameter int BINS = 16,
    parameter int MAX_SAMPLES = 1024
) (
    input logic clk,
    input logic rst_n,
    ewh_stream_if.sink in_ch,
    ewh_stream_if.source out_ch
);
    localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int TOT_W = $clog2(MAX_SAMPLES + 1);
    localparam int NUM_W = ewh_pkg::DIFF_W + BIN_W + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_DIV = 3'd3;
    localparam logic [2:0] S_PEAK = 3'd4;
    localparam logic [2:0] S_EDGE = 3'd5;
    localparam logic [2:0] S_OUT = 3'd6;

    logic [2:0] state_reg;
    logic [TOT_W-1:0] total_reg;
    logic signed [ewh_pkg::WORD_W-1:0] min_reg, max_reg;
    logic [ewh_pkg::WORD_W-1:0] mem [MAX_SAMPLES];
    logic [ewh_pkg::WORD_W-1:0] rd_reg;
    logic [TOT_W-1:0] ptr_reg;
    logic [BIN_W:0] bin_reg;
    logic [ewh_pkg::CNT_W-1:0] cnt_reg [BINS];
    logic [ewh_pkg::CNT_W-1:0] peak_reg;
    logic [ewh_pkg::DIFF_W-1:0] range_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [ewh_pkg::DIFF_W:0] rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic edge_mode_reg;
    logic out_valid_reg;
    ewh_pkg::out_item_t out_reg;

    logic full;
    logic signed [ewh_pkg::DIFF_W-1:0] diff_s;
    logic [ewh_pkg::DIFF_W:0] rem_sh;
    logic [ewh_pkg::DIFF_W-1:0] den;
    logic [BIN_W-1:0] tgt;
    logic [ewh_pkg::CNT_W-1:0] max_cnt;

    assign full = (total_reg >= TOT_W'(MAX_SAMPLES));
    assign max_cnt = ewh_pkg::CNT_W'(MAX_SAMPLES);
    assign in_ch.ready = (state_reg == S_LOAD);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;
    assign diff_s = ewh_pkg::DIFF_W'($signed(rd_reg)) - ewh_pkg::DIFF_W'(min_reg);
    assign rem_sh = {rem_reg[ewh_pkg::DIFF_W-1:0], num_reg[NUM_W-1]};
    // Sample bins divide by the range, edges divide by the bin count.
    assign den = edge_mode_reg ? ewh_pkg::DIFF_W'(BINS) : range_reg;
    // Quotient is saturated to the last bin.
    assign tgt = (quo_reg >= NUM_W'(BINS)) ? BIN_W'(BINS - 1) : quo_reg[BIN_W-1:0];

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready && !full)
        begin
            mem[total_reg[ADDR_W-1:0]] <= in_ch.data.sample_value;
        end
        rd_reg <= mem[ptr_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            total_reg <= '0;
            min_reg <= 32'sh7FFFFFFF;
            max_reg <= 32'sh80000000;
            ptr_reg <= '0;
            bin_reg <= '0;
            peak_reg <= '0;
            out_valid_reg <= 1'b0;
            step_reg <= '0;
            edge_mode_reg <= 1'b0;
            for (int i = 0; i < BINS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (in_ch.valid)
                    begin
                        if (!full)
                        begin
                            total_reg <= total_reg + 1'b1;
                            if (in_ch.data.sample_value < min_reg)
                                min_reg <= in_ch.data.sample_value;
                            if (in_ch.data.sample_value > max_reg)
                                max_reg <= in_ch.data.sample_value;
                        end
                        if (in_ch.data.last_sample)
                        begin
                            state_reg <= S_CLEAR;
                            bin_reg <= '0;
                        end
                    end
                end
                S_CLEAR:
                begin
                    cnt_reg[bin_reg[BIN_W-1:0]] <= '0;
                    range_reg <= ewh_pkg::DIFF_W'(max_reg) - ewh_pkg::DIFF_W'(min_reg);
                    ptr_reg <= '0;
                    peak_reg <= '0;
                    if (bin_reg == (BIN_W+1)'(BINS - 1))
                        state_reg <= S_READ;
                    bin_reg <= bin_reg + 1'b1;
                end
                S_READ:
                begin
                    // Memory read data is registered; it is ready in the following S_DIV state.
                    if (ptr_reg == total_reg)
                    begin
                        state_reg <= S_PEAK;
                        bin_reg <= '0;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                        step_reg <= '0;
                        edge_mode_reg <= 1'b0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        if (!edge_mode_reg)
                            num_reg <= NUM_W'(diff_s) * NUM_W'(BINS);
                        else
                            num_reg <= NUM_W'(range_reg) * NUM_W'(bin_reg);
                        rem_reg <= '0;
                        quo_reg <= '0;
                        step_reg <= step_reg + 1'b1;
                    end
                    else if (step_reg <= STEP_W'(NUM_W))
                    begin
                        num_reg <= num_reg << 1;
                        if (rem_sh >= {1'b0, den} && den != '0)
                        begin
                            rem_reg <= rem_sh - {1'b0, den};
                            quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                        end
                        step_reg <= step_reg + 1'b1;
                    end
                    else if (!edge_mode_reg)
                    begin
                        // Zero range leaves quotient zero, which is bin zero.
                        if (cnt_reg[tgt] < max_cnt)
                            cnt_reg[tgt] <= cnt_reg[tgt] + 1'b1;
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        state_reg <= S_EDGE;
                    end
                end
                S_PEAK:
                begin
                    if (cnt_reg[bin_reg[BIN_W-1:0]] > peak_reg)
                        peak_reg <= cnt_reg[bin_reg[BIN_W-1:0]];
                    if (bin_reg == (BIN_W+1)'(BINS - 1))
                    begin
                        bin_reg <= '0;
                        step_reg <= '0;
                        edge_mode_reg <= 1'b1;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        bin_reg <= bin_reg + 1'b1;
                    end
                end
                S_EDGE:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.bin_index <= ewh_pkg::IDX_W'(bin_reg);
                        // Edge quotient is below the range, fits 32 bits.
                        out_reg.bin_low_edge <= min_reg + quo_reg[ewh_pkg::WORD_W-1:0];
                        out_reg.bin_count <= cnt_reg[bin_reg[BIN_W-1:0]];
                        out_reg.peak_count <= peak_reg;
                        out_reg.last_bin <= (bin_reg == (BIN_W+1)'(BINS - 1));
                        if (bin_reg == (BIN_W+1)'(BINS - 1))
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            bin_reg <= bin_reg + 1'b1;
                            step_reg <= '0;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_OUT:
                begin
                    // Drain the final result, then start a fresh data set.
                    if (out_ch.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        total_reg <= '0;
                        min_reg <= 32'sh7FFFFFFF;
                        max_reg <= 32'sh80000000;
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
            if (state_reg != S_EDGE && state_reg != S_OUT && out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end
endmodule

// ===== tb/sv/ewh_checker.sv =====
`timescale 1ns / 1ps
module ewh_checker #(
    parameter int BINS = 16,
    parameter int MAX_SAMPLES = 1024
) (
    input logic clk,
    input logic rst_n,
    ewh_stream_if in_ch,
    ewh_stream_if out_ch,
    output int errors,
    output int pending,
    output int bins_seen
);
    logic signed [ewh_pkg::WORD_W-1:0] held_samples[$];
    longint data_min;
    longint data_max;
    ewh_pkg::out_item_t bin_results[$];

    initial begin
        errors = 0;
        bins_seen = 0;
        data_min = 64'sd2147483647;
        data_max = -64'sd2147483648;
    end

    assign pending = bin_results.size();

    task automatic predict_bins();
        longint range;
        longint diff;
        longint bin;
        int counts[BINS];
        int peak;
        ewh_pkg::out_item_t r;
        begin
            peak = 0;
            foreach (counts[i]) counts[i] = 0;
            range = (data_max >= data_min) ? data_max - data_min : 0;
            foreach (held_samples[k])
            begin
                bin = 0;
                diff = longint'(held_samples[k]) - data_min;
                if (range != 0 && diff >= 0)
                begin
                    bin = (diff * BINS) / range;
                    if (bin >= BINS) bin = BINS - 1;
                end
                if (counts[bin] < MAX_SAMPLES) counts[bin]++;
            end
            foreach (counts[i]) if (counts[i] > peak) peak = counts[i];
            for (int i = 0; i < BINS; i++)
            begin
                r.bin_index = ewh_pkg::IDX_W'(i);
                r.bin_low_edge = ewh_pkg::WORD_W'(data_min + (longint'(i) * range) / BINS);
                r.bin_count = ewh_pkg::CNT_W'(counts[i]);
                r.peak_count = ewh_pkg::CNT_W'(peak);
                r.last_bin = (i == BINS - 1);
                bin_results.push_back(r);
            end
            held_samples.delete();
            data_min = 64'sd2147483647;
            data_max = -64'sd2147483648;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            if (held_samples.size() < MAX_SAMPLES)
            begin
                held_samples.push_back(in_ch.data.sample_value);
                if (longint'(in_ch.data.sample_value) < data_min)
                    data_min = in_ch.data.sample_value;
                if (longint'(in_ch.data.sample_value) > data_max)
                    data_max = in_ch.data.sample_value;
            end
            if (in_ch.data.last_sample) predict_bins();
        end
    end

    always @(posedge clk)
    begin
        ewh_pkg::out_item_t want;
        ewh_pkg::out_item_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            bins_seen++;
            if (bin_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected bin transaction: %p", got);
            end
            else
            begin
                want = bin_results.pop_front();
                if (got.bin_index !== want.bin_index
                    || got.bin_low_edge !== want.bin_low_edge
                    || got.bin_count !== want.bin_count
                    || got.peak_count !== want.peak_count
                    || got.last_bin !== want.last_bin)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("bin mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    localparam int BINS = 16;
    localparam int MAX_SAMPLES = 1024;

    logic clk = 1'b0;
    logic rst_n;
    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int pending;
    int bins_seen;
    int random_sent;
    int runs_sent;

    ewh_stream_if #(.T(ewh_pkg::in_item_t)) in_ch ();
    ewh_stream_if #(.T(ewh_pkg::out_item_t)) out_ch ();

    equal_width_histogram #(.BINS(BINS), .MAX_SAMPLES(MAX_SAMPLES)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    ewh_checker #(.BINS(BINS), .MAX_SAMPLES(MAX_SAMPLES)) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .errors(errors),
        .pending(pending),
        .bins_seen(bins_seen)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d bins outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_sample(input logic signed [31:0] v, input logic last);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.data <= '{sample_value: v, last_sample: last};
            @(posedge clk);
            while (!in_ch.ready) @(posedge clk);
        end
    endtask

    // hold valid low until the checker has seen every bin
    task automatic drain();
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while (pending > 0) @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] pick_value(input logic signed [31:0] base,
                                                      input int spread);
        begin
            case ($urandom_range(5))
                0: pick_value = $urandom;
                1: pick_value = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
                default: pick_value = base + $signed($urandom_range(spread));
            endcase
        end
    endfunction

    task automatic random_run(input int len);
        logic signed [31:0] base;
        int spread;
        begin
            base = $urandom;
            spread = ($urandom_range(1)) ? $urandom_range(40) : $urandom_range(32'h7FFFFFFF);
            for (int k = 0; k < len; k++)
            begin
                send_sample(pick_value(base, spread), k == len - 1);
                random_sent++;
            end
            runs_sent++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_sent = 0;
        runs_sent = 0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes in one run
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh7FFFFFFF, 1'b0);
        send_sample(32'sh00000000, 1'b0);
        send_sample(32'sh00010000, 1'b0);
        send_sample(32'shFFFFFFFF, 1'b1);
        // single sample, zero range
        send_sample(32'sh12345678, 1'b1);
        // equal samples, zero range
        for (int k = 0; k < 4; k++) send_sample(-32'sh00028000, k == 3);
        // several samples at the maximum
        for (int k = 0; k < 6; k++) send_sample(k < 2 ? 32'sh0 : 32'sh00050000, k == 5);
        drain();
        // overfill the store: one bin reaches the count maximum, extra samples and the last are dropped
        for (int k = 0; k < MAX_SAMPLES + 3; k++)
            send_sample(k >= MAX_SAMPLES ? 32'sh7FFFFFFF : 32'sh00010000,
                        k == MAX_SAMPLES + 2);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            while (random_sent < 33 * (phase + 1))
                random_run($urandom_range(3) == 0 ? $urandom_range(40, 17)
                                                  : $urandom_range(16, 1));
            if (phase == 1) drain();
        end

        drain();
        repeat (50) @(posedge clk);
        $display("covered %0d random samples in %0d runs plus directed extremes,", random_sent,
                 runs_sent);
        $display("zero range and a full store; %0d bin transactions checked", bins_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
